[rtl/periodic_task_scheduler_top_defines.svh]
// assertion macros for the periodic task scheduler
// needs clk_i and rst_ni in the scope of each use
`ifndef PERIODIC_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define PTS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed: %m");
`define PTS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define PTS_ASSERT(name, prop)
`define PTS_ASSERT_IMPL(name, ante, cons)
`endif

`endif

[rtl/pts_pkg.sv]
// shared constants and types of the periodic task scheduler
// no dependencies
`default_nettype none

package pts_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int COUNT_BITS = 16;
  localparam int SLOT_BITS  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int FUNC_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int PERIOD_W = 16;
  localparam int TAG_W    = 16;

  localparam int IN_DATA_W  = SLOT_W + PERIOD_W + 2 * TAG_W;
  localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = SLOT_W + 2 * TAG_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_ADD      = 2'd1,
    FUNC_DISPATCH = 2'd2
  } func_e;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [TAG_W-1:0]      tag_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period_ticks;
    tag_t                entry_tag;
    tag_t                argument_tag;
  } item_t;

endpackage

`default_nettype wire

[rtl/periodic_task_scheduler_top.sv]
// periodic task scheduler: slot table, tick / add / dispatch, output register
// depends on pts_pkg and periodic_task_scheduler_top_defines.svh
`default_nettype none
`include "periodic_task_scheduler_top_defines.svh"

// usage
// - input channel s_axis: tuser carries the operation code (tick, add, dispatch),
//   tdata carries slot, period, entry tag and argument tag for add
// - output channel m_axis: exactly one item per input item, in order;
//   tuser is the found flag, tdata the chosen slot and its two tags
//   (all zero when nothing was dispatched, and for tick and add)
// - path: an accepted item is held in the input register, then worked on as it
//   moves into the output register, whose result is shown from then on; m_axis_tvalid
//   rises once that move is made, which needs the output side to be free
// - throughput: one item per cycle while the output side takes results; the whole slot
//   table (countdowns, ready flags, priority pick) is updated at once from the input register
// - reset: every slot is empty and not ready, both pipeline registers empty;
//   periods, countdowns and tags are not cleared and are written by add
// - stall: when m_axis_tready is low the result holds, the input register
//   keeps one more item and s_axis_tready then falls until the result is taken
// - unused operation code: no state change, result all zero
module periodic_task_scheduler_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // input channel
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // tuser: func[1:0]
  input  wire  [pts_pkg::FUNC_W-1:0]       s_axis_tuser,
  // tdata: slot[2:0], period_ticks[18:3], entry_tag[34:19], argument_tag[50:35], zero pad
  input  wire  [pts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // output channel
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // tuser: found[0]
  output logic                             m_axis_tuser,
  // tdata: chosen_slot[2:0], chosen_entry[18:3], chosen_argument[34:19], zero pad
  output logic [pts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int N  = pts_pkg::NUM_SLOTS;
  localparam int SB = pts_pkg::SLOT_BITS;

  // input register
  logic           in_valid_q;
  pts_pkg::item_t in_q;
  logic           advance;

  // slot table
  logic [N-1:0]          active_q, active_d;
  logic [N-1:0]          ready_q, ready_d;
  pts_pkg::count_t       count_q  [N];
  pts_pkg::count_t       count_d  [N];
  pts_pkg::count_t       period_q [N];
  pts_pkg::tag_t         entry_q  [N];
  pts_pkg::tag_t         arg_q    [N];

  // output register
  logic                          out_valid_q;
  logic                          found_q, found_d;
  logic [pts_pkg::SLOT_W-1:0]    cslot_q, cslot_d;
  pts_pkg::tag_t                 centry_q, centry_d;
  pts_pkg::tag_t                 carg_q, carg_d;

  // decode
  pts_pkg::func_e  func;
  logic            do_tick, do_add, do_disp;
  logic            add_ok;
  logic [SB-1:0]   add_idx;
  pts_pkg::count_t add_period;

  // dispatch pick
  logic [N-1:0]    cand;
  logic [N-1:0]    pick_oh;
  logic [SB-1:0]   pick_idx;
  logic            any_ready;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.func         <= s_axis_tuser;
      in_q.slot         <= s_axis_tdata[2:0];
      in_q.period_ticks <= s_axis_tdata[18:3];
      in_q.entry_tag    <= s_axis_tdata[34:19];
      in_q.argument_tag <= s_axis_tdata[50:35];
    end
  end

  // operation decode
  always_comb begin
    func    = pts_pkg::func_e'(in_q.func);
    do_tick = 1'b0;
    do_add  = 1'b0;
    do_disp = 1'b0;
    case (func)
      pts_pkg::FUNC_TICK:     do_tick = 1'b1;
      pts_pkg::FUNC_ADD:      do_add  = 1'b1;
      pts_pkg::FUNC_DISPATCH: do_disp = 1'b1;
      default: ;
    endcase
  end

  assign add_ok     = (32'(in_q.slot) < N);
  assign add_idx    = SB'(in_q.slot);
  assign add_period = pts_pkg::COUNT_BITS'(in_q.period_ticks);

  // lowest-numbered ready slot wins
  assign cand = active_q & ready_q;
  always_comb begin
    pick_oh  = '0;
    pick_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick_oh    = '0;
        pick_oh[i] = 1'b1;
        pick_idx   = SB'(i);
      end
    end
  end
  assign any_ready = |cand;

  // next state of the table
  always_comb begin
    active_d = active_q;
    ready_d  = ready_q;
    for (int i = 0; i < N; i++) begin
      count_d[i] = count_q[i];
      if (do_tick && active_q[i]) begin
        if (count_q[i] == '0) begin
          count_d[i] = period_q[i];
        end else begin
          count_d[i] = count_q[i] - 1'b1;
          if (count_q[i] == pts_pkg::count_t'(1)) begin
            ready_d[i] = 1'b1;
          end
        end
      end
    end
    if (do_add && add_ok) begin
      active_d[add_idx] = 1'b1;
      ready_d[add_idx]  = 1'b0;
      count_d[add_idx]  = add_period;
    end
    if (do_disp) begin
      ready_d = ready_q & ~pick_oh;
    end
  end

  // result of this item
  always_comb begin
    found_d  = 1'b0;
    cslot_d  = '0;
    centry_d = '0;
    carg_d   = '0;
    if (do_disp && any_ready) begin
      found_d  = 1'b1;
      cslot_d  = pts_pkg::SLOT_W'(pick_idx);
      centry_d = entry_q[pick_idx];
      carg_d   = arg_q[pick_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      ready_q  <= '0;
    end else if (advance) begin
      active_q <= active_d;
      ready_q  <= ready_d;
    end
  end

  // countdowns, periods and tags: no reset, written by add before use
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i < N; i++) begin
        count_q[i] <= count_d[i];
      end
      if (do_add && add_ok) begin
        period_q[add_idx] <= add_period;
        entry_q[add_idx]  <= in_q.entry_tag;
        arg_q[add_idx]    <= in_q.argument_tag;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      found_q  <= found_d;
      cslot_q  <= cslot_d;
      centry_q <= centry_d;
      carg_q   <= carg_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = found_q;
  assign m_axis_tdata  = pts_pkg::OUT_TDATA_W'({carg_q, centry_q, cslot_q});

  // checks
  `PTS_ASSERT(a_ready_needs_active, (ready_q & ~active_q) == '0)
  `PTS_ASSERT(a_no_found_zero_data, !(out_valid_q && !found_q) || (m_axis_tdata == '0))
  `PTS_ASSERT_IMPL(a_dispatch_clears_pick, advance && do_disp, ready_q == ($past(ready_q) & ~$past(pick_oh)))
  `PTS_ASSERT_IMPL(a_input_held, in_valid_q && !advance, in_valid_q && $stable(in_q))

endmodule

`default_nettype wire
